// ===== design/lpmr_pkg.sv =====
`timescale 1ns / 1ps

package lpmr_pkg;

  // Default sizes of the byte ring.
  localparam int unsigned DepthDef  = 1024;
  localparam int unsigned MaxMsgDef = 64;

  // Fixed field widths.
  localparam int unsigned LenW  = 7;
  localparam int unsigned DataW = 8;
  localparam int unsigned StatW = 2;

  // Every stored message opens with a 4-byte little-endian length header.
  localparam int unsigned HdrBytes = 4;

  // Entries in the command queue between front and back.
  localparam int unsigned QDepth = 2;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  // Command classes produced by the front.
  typedef enum logic [1:0] {
    CMD_WR_FIRST = 2'd0,
    CMD_WR_BYTE  = 2'd1,
    CMD_READ     = 2'd2
  } cmd_e;

  // One classified command in the queue.
  typedef struct packed {
    cmd_e             op;
    logic             too_long;
    logic [LenW-1:0]  msg_len;
    logic [DataW-1:0] data;
  } cmd_t;

  // One result produced by the back before the output register.
  typedef struct packed {
    logic             strobe;
    status_e          status;
    logic [DataW-1:0] data;
    logic             data_valid;
    logic             last;
  } res_t;

endpackage

// ===== design/lpmr_front.sv =====
`timescale 1ns / 1ps

module lpmr_front #(
  parameter int unsigned MAX_MSG = lpmr_pkg::MaxMsgDef
) (
  input  logic                       start_i,
  input  logic                       kind_i,
  input  logic                       first_i,
  input  logic [lpmr_pkg::LenW-1:0]  msg_len_i,
  input  logic [lpmr_pkg::DataW-1:0] data_in_i,
  input  logic                       q_full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output lpmr_pkg::cmd_t             cmd_o
);

  // A transaction is taken whenever the queue has room.
  assign busy_o = q_full_i;
  assign push_o = start_i & ~q_full_i;

  // Classify the item and flag a length above MAX_MSG.
  always_comb begin
    if (kind_i) begin
      cmd_o.op = lpmr_pkg::CMD_READ;
    end else if (first_i) begin
      cmd_o.op = lpmr_pkg::CMD_WR_FIRST;
    end else begin
      cmd_o.op = lpmr_pkg::CMD_WR_BYTE;
    end
    cmd_o.too_long = (msg_len_i > lpmr_pkg::LenW'(MAX_MSG));
    cmd_o.msg_len  = msg_len_i;
    cmd_o.data     = data_in_i;
  end

endmodule

// ===== design/lpmr_queue.sv =====
`timescale 1ns / 1ps

module lpmr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpmr_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output lpmr_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned IdxW = $clog2(lpmr_pkg::QDepth);
  localparam int unsigned CntW = $clog2(lpmr_pkg::QDepth + 1);

  lpmr_pkg::cmd_t  slot_q [lpmr_pkg::QDepth];
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(lpmr_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_idx_q];

  // Pointer and fill count update.
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    if (push_i) begin
      wr_idx_d = (wr_idx_q == IdxW'(lpmr_pkg::QDepth - 1)) ? '0 : wr_idx_q + IdxW'(1);
    end
    if (pop_i) begin
      rd_idx_d = (rd_idx_q == IdxW'(lpmr_pkg::QDepth - 1)) ? '0 : rd_idx_q + IdxW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_idx_q] <= cmd_i;
    end
  end

endmodule

// ===== design/lpmr_back.sv =====
`timescale 1ns / 1ps

module lpmr_back #(
  parameter int unsigned DEPTH   = lpmr_pkg::DepthDef,
  parameter int unsigned MAX_MSG = lpmr_pkg::MaxMsgDef,
  parameter int unsigned FreeW   = $clog2(DEPTH) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  lpmr_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic [lpmr_pkg::StatW-1:0] status_o,
  output logic [lpmr_pkg::DataW-1:0] data_out_o,
  output logic                       data_valid_o,
  output logic                       last_o,
  output logic [FreeW-1:0]           free_space_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = AW + 8;
  localparam int unsigned LenW  = lpmr_pkg::LenW;
  localparam int unsigned DataW = lpmr_pkg::DataW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WDATA  = 3'd1;
  localparam logic [2:0] S_HDR    = 3'd2;
  localparam logic [2:0] S_LEN    = 3'd3;
  localparam logic [2:0] S_STREAM = 3'd4;

  // Ring arithmetic that also holds for a depth that is not a power of two.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [7:0] k);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(k);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_dist(input logic [AW-1:0] w, input logic [AW-1:0] r);
    logic [AW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + (AW+1)'(DEPTH);
    end
    return d[AW-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    cwp_q, cwp_d;
  logic [AW-1:0]    wwp_q, wwp_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic [AW-1:0]    saddr_q, saddr_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             drop_q, drop_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [DataW-1:0] dat_q, dat_d;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;
  logic [AW-1:0]    raddr;

  lpmr_pkg::res_t   res_q, res_d;
  logic [AW-1:0]    used_c;
  logic             fits;

  // Space check against the committed pointer, since a new message abandons any open one.
  assign used_c = ptr_dist(cwp_q, rp_q);
  assign fits   = (SW'(used_c) + SW'(cmd_i.msg_len) + SW'(lpmr_pkg::HdrBytes))
                  <= SW'(DEPTH - 1);

  // Sequencer for writes and reads of the byte ring.
  always_comb begin
    state_d = state_q;
    cwp_d   = cwp_q;
    wwp_d   = wwp_q;
    rp_d    = rp_q;
    saddr_d = saddr_q;
    rem_d   = rem_q;
    drop_d  = drop_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    dat_d   = dat_q;
    res_d   = '0;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = wwp_q;
    wdata   = cmd_i.data;
    raddr   = rp_q;

    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            lpmr_pkg::CMD_WR_FIRST: begin
              wwp_d        = cwp_q;
              rem_d        = '0;
              drop_d       = 1'b0;
              res_d.strobe = 1'b1;
              res_d.last   = 1'b1;
              if (cmd_i.too_long || !fits) begin
                res_d.status = lpmr_pkg::ST_REJECT;
                if (cmd_i.msg_len != '0) begin
                  rem_d  = cmd_i.msg_len - LenW'(1);
                  drop_d = (cmd_i.msg_len != LenW'(1));
                end
              end else begin
                // Store the length byte; the upper header bytes are never read back.
                we    = 1'b1;
                waddr = cwp_q;
                wdata = DataW'(cmd_i.msg_len);
                wwp_d = ptr_add(cwp_q, 8'(lpmr_pkg::HdrBytes));
                if (cmd_i.msg_len == '0) begin
                  cwp_d = wwp_d;
                end else begin
                  // The first payload byte goes in on the next cycle.
                  res_d.strobe = 1'b0;
                  rem_d        = cmd_i.msg_len - LenW'(1);
                  dat_d        = cmd_i.data;
                  state_d      = S_WDATA;
                end
              end
            end
            lpmr_pkg::CMD_WR_BYTE: begin
              res_d.strobe = 1'b1;
              res_d.last   = 1'b1;
              if (rem_q != '0) begin
                rem_d = rem_q - LenW'(1);
                if (drop_q) begin
                  res_d.status = lpmr_pkg::ST_REJECT;
                  if (rem_q == LenW'(1)) begin
                    drop_d = 1'b0;
                  end
                end else begin
                  we    = 1'b1;
                  waddr = wwp_q;
                  wdata = cmd_i.data;
                  wwp_d = ptr_inc(wwp_q);
                  if (rem_q == LenW'(1)) begin
                    cwp_d = wwp_d;
                  end
                end
              end
            end
            lpmr_pkg::CMD_READ: begin
              if (cwp_q == rp_q) begin
                res_d.strobe = 1'b1;
                res_d.status = lpmr_pkg::ST_EMPTY;
                res_d.last   = 1'b1;
              end else begin
                raddr   = rp_q;
                state_d = S_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WDATA: begin
        we           = 1'b1;
        waddr        = wwp_q;
        wdata        = dat_q;
        wwp_d        = ptr_inc(wwp_q);
        if (rem_q == '0) begin
          cwp_d = wwp_d;
        end
        res_d.strobe = 1'b1;
        res_d.last   = 1'b1;
        state_d      = S_IDLE;
      end
      S_HDR: begin
        // The length byte of the oldest message is in the read register now.
        cnt_d   = (rdata_q > DataW'(MAX_MSG)) ? LenW'(MAX_MSG) : rdata_q[LenW-1:0];
        saddr_d = ptr_add(rp_q, 8'(lpmr_pkg::HdrBytes));
        state_d = S_LEN;
      end
      S_LEN: begin
        raddr   = saddr_q;
        saddr_d = ptr_inc(saddr_q);
        rp_d    = ptr_add(rp_q, 8'(lpmr_pkg::HdrBytes) + 8'(cnt_q));
        left_d  = cnt_q;
        if (cnt_q == '0) begin
          res_d.strobe = 1'b1;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_STREAM;
        end
      end
      S_STREAM: begin
        raddr            = saddr_q;
        saddr_d          = ptr_inc(saddr_q);
        res_d.strobe     = 1'b1;
        res_d.data       = rdata_q;
        res_d.data_valid = 1'b1;
        res_d.last       = (left_q == LenW'(1));
        left_d           = left_q - LenW'(1);
        if (left_q == LenW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and the staged result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cwp_q    <= '0;
      wwp_q    <= '0;
      rp_q     <= '0;
      rem_q    <= '0;
      drop_q   <= 1'b0;
      res_q    <= '0;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      cwp_q    <= cwp_d;
      wwp_q    <= wwp_d;
      rp_q     <= rp_d;
      rem_q    <= rem_d;
      drop_q   <= drop_d;
      res_q    <= res_d;
      strobe_o <= res_q.strobe;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    saddr_q <= saddr_d;
    cnt_q   <= cnt_d;
    left_q  <= left_d;
    dat_q   <= dat_d;
  end

  // Output register; free space is taken from the pointers as the step left them.
  always_ff @(posedge clk_i) begin
    status_o     <= res_q.status;
    data_out_o   <= res_q.data;
    data_valid_o <= res_q.data_valid;
    last_o       <= res_q.last;
    free_space_o <= FreeW'(DEPTH - 1) - FreeW'(ptr_dist(wwp_q, rp_q));
  end

  // Byte store with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

// ===== design/length_prefixed_message_ring_unit.sv =====
`timescale 1ns / 1ps

// Channel    Handshake               Ports
// command    start_i high, busy_o    kind_i, first_i, msg_len_i, data_in_i
//            low
// result     strobe_o, one cycle     status_o, data_out_o, data_valid_o, last_o,
//                                    free_space_o
//
// In the back end, other write bytes are handled in S_IDLE; the first byte of
// an accepted non-empty message also needs S_WDATA, since the single write
// port of the byte store stores the length byte of the header and then the
// payload byte. A read passes through S_HDR and S_LEN to fetch and decode the
// header through the registered read port, then streams one byte per cycle;
// an empty-ring read is answered from S_IDLE. Results pass through the staged
// result register and then the output register. A two-entry command queue
// lets the front accept while the back works; busy_o rises only when that
// queue is full. Reset is asynchronous and active low and leaves the ring
// empty; the byte store needs no clearing. The receiver cannot stall results.

module length_prefixed_message_ring_unit #(
  parameter int unsigned DEPTH   = lpmr_pkg::DepthDef,
  parameter int unsigned MAX_MSG = lpmr_pkg::MaxMsgDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic                          first_i,
  input  logic [lpmr_pkg::LenW-1:0]     msg_len_i,
  input  logic [lpmr_pkg::DataW-1:0]    data_in_i,
  output logic                          strobe_o,
  output logic [lpmr_pkg::StatW-1:0]    status_o,
  output logic [lpmr_pkg::DataW-1:0]    data_out_o,
  output logic                          data_valid_o,
  output logic                          last_o,
  output logic [$clog2(DEPTH):0]        free_space_o
);

  localparam int unsigned FreeW = $clog2(DEPTH) + 1;

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  lpmr_pkg::cmd_t cmd_in;
  lpmr_pkg::cmd_t cmd_head;

  // Front end: accepts and classifies each transaction.
  lpmr_front #(
    .MAX_MSG (MAX_MSG)
  ) u_front (
    .start_i   (start_i),
    .kind_i    (kind_i),
    .first_i   (first_i),
    .msg_len_i (msg_len_i),
    .data_in_i (data_in_i),
    .q_full_i  (q_full),
    .busy_o    (busy_o),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  // Command queue between the two ends.
  lpmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: ring pointers, byte store and result generation.
  lpmr_back #(
    .DEPTH   (DEPTH),
    .MAX_MSG (MAX_MSG),
    .FreeW   (FreeW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (~q_empty),
    .cmd_i        (cmd_head),
    .pop_o        (pop),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .data_valid_o (data_valid_o),
    .last_o       (last_o),
    .free_space_o (free_space_o)
  );

endmodule

// ===== tb/lpmr_result_checker.sv =====
`timescale 1ns / 1ps

module lpmr_result_checker #(
  parameter int unsigned DEPTH   = lpmr_pkg::DepthDef,
  parameter int unsigned MAX_MSG = lpmr_pkg::MaxMsgDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       kind_i,
  input  logic                       first_i,
  input  logic [lpmr_pkg::LenW-1:0]  msg_len_i,
  input  logic [lpmr_pkg::DataW-1:0] data_in_i,
  input  logic                       strobe_i,
  input  logic [lpmr_pkg::StatW-1:0] status_i,
  input  logic [lpmr_pkg::DataW-1:0] data_out_i,
  input  logic                       data_valid_i,
  input  logic                       last_i,
  input  logic [$clog2(DEPTH):0]     free_space_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o
);

  localparam int unsigned FreeW = $clog2(DEPTH) + 1;

  // One predicted result transaction.
  typedef struct {
    lpmr_pkg::status_e          status;
    logic [lpmr_pkg::DataW-1:0] data;
    logic                       data_valid;
    logic                       last;
    logic [FreeW-1:0]           free_space;
  } ring_result_t;

  // Shadow copy of the ring and its pointers.
  logic [lpmr_pkg::DataW-1:0] ring_image [DEPTH];
  int unsigned      commit_ptr;
  int unsigned      open_ptr;
  int unsigned      read_ptr;
  int unsigned      bytes_left;
  logic             discarding;

  ring_result_t     expected_results [$];
  ring_result_t     oldest;
  int               mismatches;

  // Usable free bytes; an open message already holds its room.
  function automatic int unsigned ring_free();
    return (DEPTH - 1) - ((open_ptr + DEPTH - read_ptr) % DEPTH);
  endfunction

  task automatic store_byte(input logic [lpmr_pkg::DataW-1:0] value);
    ring_image[open_ptr] = value;
    open_ptr = (open_ptr + 1) % DEPTH;
  endtask

  function automatic logic [lpmr_pkg::DataW-1:0] fetch_byte();
    logic [lpmr_pkg::DataW-1:0] value;
    value = ring_image[read_ptr];
    read_ptr = (read_ptr + 1) % DEPTH;
    return value;
  endfunction

  task automatic queue_result(input lpmr_pkg::status_e st,
                              input logic [lpmr_pkg::DataW-1:0] data,
                              input logic valid, input logic is_last);
    ring_result_t r;
    r.status     = st;
    r.data       = data;
    r.data_valid = valid;
    r.last       = is_last;
    r.free_space = FreeW'(ring_free());
    expected_results.push_back(r);
  endtask

  // Work out every result that one accepted command transaction causes.
  task automatic model_command(input logic kind, input logic first,
                               input logic [lpmr_pkg::LenW-1:0] len,
                               input logic [lpmr_pkg::DataW-1:0] dat);
    lpmr_pkg::status_e          st;
    int unsigned                stored_len;
    logic [lpmr_pkg::DataW-1:0] payload [MAX_MSG];
    st = lpmr_pkg::ST_OK;
    if (!kind) begin
      if (first) begin
        // A new message abandons whatever was still open.
        open_ptr   = commit_ptr;
        bytes_left = 0;
        discarding = 1'b0;
        if (len > MAX_MSG || 32'(len) + lpmr_pkg::HdrBytes > ring_free()) begin
          st = lpmr_pkg::ST_REJECT;
          if (len > 0) begin
            discarding = 1'b1;
            bytes_left = len - 1;
          end
          if (bytes_left == 0) discarding = 1'b0;
        end else begin
          for (int h = 0; h < lpmr_pkg::HdrBytes; h++) begin
            store_byte(lpmr_pkg::DataW'(32'(len) >> (8 * h)));
          end
          if (len > 0) begin
            store_byte(dat);
            bytes_left = len - 1;
          end
          if (bytes_left == 0) commit_ptr = open_ptr;
        end
      end else if (bytes_left > 0) begin
        bytes_left--;
        if (discarding) begin
          st = lpmr_pkg::ST_REJECT;
          if (bytes_left == 0) discarding = 1'b0;
        end else begin
          store_byte(dat);
          if (bytes_left == 0) commit_ptr = open_ptr;
        end
      end
      queue_result(st, '0, 1'b0, 1'b1);
    end else if (commit_ptr == read_ptr) begin
      queue_result(lpmr_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
    end else begin
      stored_len = 0;
      for (int h = 0; h < lpmr_pkg::HdrBytes; h++) begin
        stored_len |= 32'(fetch_byte()) << (8 * h);
      end
      if (stored_len > MAX_MSG) stored_len = MAX_MSG;
      for (int i = 0; i < stored_len; i++) begin
        payload[i] = fetch_byte();
      end
      if (stored_len == 0) begin
        queue_result(lpmr_pkg::ST_OK, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < stored_len; i++) begin
          queue_result(lpmr_pkg::ST_OK, payload[i], 1'b1, (i + 1 == stored_len));
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check each result transaction, then predict from the accepted command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_ptr = 0;
      open_ptr   = 0;
      read_ptr   = 0;
      bytes_left = 0;
      discarding = 1'b0;
      mismatches = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (strobe_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual status %0d",
                   $time, status_i);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("status", 32'(oldest.status), 32'(status_i));
          compare_field("data_out", 32'(oldest.data), 32'(data_out_i));
          compare_field("data_valid", 32'(oldest.data_valid), 32'(data_valid_i));
          compare_field("last", 32'(oldest.last), 32'(last_i));
          compare_field("free_space", 32'(oldest.free_space), 32'(free_space_i));
        end
      end
      if (start_i && !busy_i) begin
        model_command(kind_i, first_i, msg_len_i, data_in_i);
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_results.size();
    end
  end

endmodule

// ===== tb/length_prefixed_message_ring_unit_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_message_ring_unit_tb;

  localparam int unsigned RingDepth   = lpmr_pkg::DepthDef;
  localparam int unsigned MaxPayload  = lpmr_pkg::MaxMsgDef;
  localparam int          RandomItems = 55;
  localparam int          CycleLimit  = 400000;
  localparam int          EndSettle   = 100;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       kind;
  logic                       first;
  logic [lpmr_pkg::LenW-1:0]  msg_len;
  logic [lpmr_pkg::DataW-1:0] data_in;
  logic                       strobe;
  logic [lpmr_pkg::StatW-1:0] status;
  logic [lpmr_pkg::DataW-1:0] data_out;
  logic                       data_valid;
  logic                       last;
  logic [$clog2(RingDepth):0] free_space;

  int mismatch_count;
  int pending_count;
  int cycle_count;
  int items_sent;
  bit idle_enable;

  length_prefixed_message_ring_unit #(
    .DEPTH  (RingDepth),
    .MAX_MSG(MaxPayload)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .kind_i      (kind),
    .first_i     (first),
    .msg_len_i   (msg_len),
    .data_in_i   (data_in),
    .strobe_o    (strobe),
    .status_o    (status),
    .data_out_o  (data_out),
    .data_valid_o(data_valid),
    .last_o      (last),
    .free_space_o(free_space)
  );

  lpmr_result_checker #(
    .DEPTH  (RingDepth),
    .MAX_MSG(MaxPayload)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind),
    .first_i         (first),
    .msg_len_i       (msg_len),
    .data_in_i       (data_in),
    .strobe_i        (strobe),
    .status_i        (status),
    .data_out_i      (data_out),
    .data_valid_i    (data_valid),
    .last_i          (last),
    .free_space_i    (free_space),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // Free-running clock, 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("length_prefixed_message_ring_unit_tb: done, errors");
      $finish;
    end
  end

  // Present one command transaction and hold it until the block takes it.
  task automatic send_command(input logic k, input logic f,
                              input logic [lpmr_pkg::LenW-1:0] len,
                              input logic [lpmr_pkg::DataW-1:0] dat);
    if (idle_enable && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    kind    <= k;
    first   <= f;
    msg_len <= len;
    data_in <= dat;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_read();
    send_command(1'b1, 1'($urandom), lpmr_pkg::LenW'($urandom), lpmr_pkg::DataW'($urandom));
  endtask

  task automatic send_stray(input logic [lpmr_pkg::DataW-1:0] dat);
    send_command(1'b0, 1'b0, lpmr_pkg::LenW'($urandom), dat);
  endtask

  // Write a message of len bytes, but send only the first item_count items.
  task automatic send_message(input int len, input int item_count);
    send_command(1'b0, 1'b1, lpmr_pkg::LenW'(len), lpmr_pkg::DataW'($urandom));
    for (int i = 1; i < item_count; i++) begin
      send_stray(lpmr_pkg::DataW'($urandom));
    end
  endtask

  task automatic send_whole_message(input int len);
    send_message(len, (len > 0) ? len : 1);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int choice;
    int len;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    kind        <= 1'b0;
    first       <= 1'b0;
    msg_len     <= '0;
    data_in     <= '0;
    items_sent  = 0;
    idle_enable = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, zero-length message, extreme bytes.
    send_read();
    send_whole_message(0);
    send_read();
    send_command(1'b0, 1'b1, lpmr_pkg::LenW'(1), 8'hFF);
    send_command(1'b0, 1'b1, lpmr_pkg::LenW'(2), 8'h00);
    send_stray(8'hFF);
    // Stray byte with no message open.
    send_stray(8'hA5);
    // Unfinished message abandoned by a new one.
    send_message(3, 2);
    send_command(1'b0, 1'b1, lpmr_pkg::LenW'(1), 8'h5A);
    // Over-long messages are rejected and their bytes dropped.
    send_message(MaxPayload + 1, 3);
    send_message(2 ** lpmr_pkg::LenW - 1, 2);
    // A read while a message is open sees only committed data.
    send_message(2, 1);
    send_read();
    send_stray(8'h81);
    repeat (5) send_read();
    wait_drained();

    // A stretch without idling: messages and reads back to back.
    idle_enable = 1'b0;
    send_whole_message(MaxPayload / 2);
    send_whole_message(0);
    send_stray(lpmr_pkg::DataW'($urandom));
    repeat (3) send_read();
    idle_enable = 1'b1;
    wait_drained();

    // Random mix: mostly whole messages, with reads and broken sequences.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      choice = $urandom_range(99);
      if (choice < 55) begin
        case ($urandom_range(19))
          0:       len = MaxPayload;
          1, 2, 3: len = $urandom_range(40, 9);
          default: len = $urandom_range(8, 0);
        endcase
        send_whole_message(len);
      end else if (choice < 75) begin
        send_read();
      end else if (choice < 85) begin
        len = $urandom_range(10, 2);
        send_message(len, $urandom_range(len - 1, 1));
      end else if (choice < 92) begin
        send_stray(lpmr_pkg::DataW'($urandom));
      end else if (choice < 97) begin
        len = $urandom_range(2 ** lpmr_pkg::LenW - 1, 0);
        send_message(len, $urandom_range(3, 1));
      end else begin
        wait_drained();
      end
    end
    repeat (6) send_read();

    wait_drained();
    repeat (EndSettle) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("length_prefixed_message_ring_unit_tb: done, clean");
    end else begin
      $display("length_prefixed_message_ring_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== length_prefixed_message_ring_unit.f =====
design/lpmr_pkg.sv
design/lpmr_front.sv
design/lpmr_queue.sv
design/lpmr_back.sv
design/length_prefixed_message_ring_unit.sv
tb/lpmr_result_checker.sv
tb/length_prefixed_message_ring_unit_tb.sv
